>>> hdl/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types and constants for the differential drive speed mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

  localparam int unsigned FULL_SCALE = 100;
  localparam int unsigned SPEED_STEP = 10;
  localparam int unsigned SLOW_FLOOR = 20;

  // reciprocal of 100 as 5243 / 2^19, exact for products up to 100 * 100
  localparam int unsigned RECIP_MUL   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [6:0] MIN_DRIVE_RESET = 7'd40;
  localparam logic [6:0] SPIN_RESET      = 7'd50;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_MIN_DRIVE = 1'b0,
    REG_SPIN      = 1'b1
  } reg_idx_t;

  // command codes
  typedef enum logic [2:0] {
    KIND_FORWARD   = 3'd0,
    KIND_BACKWARD  = 3'd1,
    KIND_TURN      = 3'd2,
    KIND_STOP      = 3'd3,
    KIND_SPEED_UP  = 3'd4,
    KIND_SLOW_DOWN = 3'd5
  } kind_t;

  // decoded command held in the input register
  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  outer;     // clamped drive speed
    logic [13:0] inner_prod; // outer * (100 - |rate|)
    logic        rate_neg;
    logic        rate_pos;
    logic        dir_neg;
    logic        dir_pos;
    logic [6:0]  spin;      // spin speed capped to full scale
  } prep_t;

endpackage : dds_pkg

`default_nettype wire

>>> hdl/dds_cmd_if.sv
// ----------------------------------------------------------------------------
// dds_cmd_if
// Drive command channel: valid, ready and the command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dds_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [7:0] turn_rate;
  logic [7:0]        speed;
  logic signed [9:0] turn_direction;

  modport source (output valid, kind, turn_rate, speed, turn_direction, input ready);
  modport sink   (input valid, kind, turn_rate, speed, turn_direction, output ready);
endinterface : dds_cmd_if

`default_nettype wire

>>> hdl/dds_res_if.sv
// ----------------------------------------------------------------------------
// dds_res_if
// Wheel speed result channel: valid, ready and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dds_res_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] left_speed;
  logic signed [7:0] right_speed;
  logic              applied;

  modport source (output valid, left_speed, right_speed, applied, input ready);
  modport sink   (input valid, left_speed, right_speed, applied, output ready);
endinterface : dds_res_if

`default_nettype wire

>>> hdl/differential_drive_speed_mixer_unit.sv
// ----------------------------------------------------------------------------
// differential_drive_speed_mixer_unit
// Keeps left and right wheel speed commands and updates them per drive word.
// ----------------------------------------------------------------------------
// path: the input register holds a command word, the wheel levels its result
// throughput: one command word per cycle while results are taken; the input
//   and result registers decouple the channels, with the wheel levels updated
//   as a word leaves the input register
// reset: wheel levels go to zero, minimum drive speed to 40, spin speed to 50
`default_nettype none

module differential_drive_speed_mixer_unit
  import dds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  dds_cmd_if.sink    cmd,
  dds_res_if.source  res,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data
);

  logic [6:0]        min_drive_speed;
  logic [6:0]        spin_speed;
  prep_t             prep_in;
  prep_t             prep_q;
  logic              in_valid;
  logic              out_valid;
  logic              advance;
  logic signed [7:0] left_level;
  logic signed [7:0] right_level;
  logic signed [7:0] left_next;
  logic signed [7:0] right_next;
  logic              applied;
  logic              applied_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_drive_speed <= MIN_DRIVE_RESET;
      spin_speed      <= SPIN_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MIN_DRIVE: min_drive_speed <= cfg_data;
        REG_SPIN:      spin_speed      <= cfg_data;
        default:       min_drive_speed <= min_drive_speed;
      endcase
    end
  end

  dds_prep u_prep (
    .kind            (cmd.kind),
    .turn_rate       (cmd.turn_rate),
    .speed           (cmd.speed),
    .turn_direction  (cmd.turn_direction),
    .min_drive_speed (min_drive_speed),
    .spin_speed      (spin_speed),
    .prep            (prep_in)
  );

  // handshake control
  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      prep_q <= prep_in;
    end
  end

  dds_update u_update (
    .prep         (prep_q),
    .left_level   (left_level),
    .right_level  (right_level),
    .left_next    (left_next),
    .right_next   (right_next),
    .applied_next (applied_next)
  );

  // wheel levels double as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      left_level  <= 8'sd0;
      right_level <= 8'sd0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      left_level  <= left_next;
      right_level <= right_next;
      out_valid   <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      applied <= applied_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.left_speed  = left_level;
  assign res.right_speed = right_level;
  assign res.applied     = applied;

  // wheel levels stay within full scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (left_level >= -8'sd100) && (left_level <= 8'sd100) &&
    (right_level >= -8'sd100) && (right_level <= 8'sd100))
    else $error("wheel level out of range");

  // a full input register with a stalled result blocks new words
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !res.ready) |-> !cmd.ready)
    else $error("command taken while pipeline stalled");

  // a stop word always leaves both wheels at zero and reports applied
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && prep_q.kind == KIND_STOP) |=>
      (left_level == 8'sd0 && right_level == 8'sd0 && applied))
    else $error("stop did not zero wheels");

  // a refused word leaves the wheel levels unchanged
  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && !applied_next) |=> (left_level == $past(left_level) &&
      right_level == $past(right_level)))
    else $error("refused word changed wheel levels");

endmodule : differential_drive_speed_mixer_unit

`default_nettype wire

>>> hdl/dds_prep.sv
// ----------------------------------------------------------------------------
// dds_prep
// Clamps the incoming command fields and forms the inner wheel product.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_prep
  import dds_pkg::*;
(
  input  logic [2:0]        kind,
  input  logic signed [7:0] turn_rate,
  input  logic [7:0]        speed,
  input  logic signed [9:0] turn_direction,
  input  logic [6:0]        min_drive_speed,
  input  logic [6:0]        spin_speed,
  output prep_t             prep
);

  localparam logic [6:0] FULL7 = 7'(FULL_SCALE);

  logic [6:0] min_cap;
  logic [6:0] spd_cap;
  logic [6:0] outer;
  logic [6:0] rate_mag;
  logic [6:0] factor;

  // clamp speed and raise small nonzero values to the minimum
  always_comb begin
    min_cap = (min_drive_speed > FULL7) ? FULL7 : min_drive_speed;
    spd_cap = (speed > 8'(FULL_SCALE)) ? FULL7 : speed[6:0];
    outer   = (spd_cap != 7'd0 && spd_cap < min_cap) ? min_cap : spd_cap;
  end

  // steering magnitude clamped to full scale
  always_comb begin
    if (turn_rate < -8'sd100 || turn_rate > 8'sd100) begin
      rate_mag = FULL7;
    end else if (turn_rate < 8'sd0) begin
      rate_mag = 7'(-turn_rate);
    end else begin
      rate_mag = turn_rate[6:0];
    end
    factor = FULL7 - rate_mag;
  end

  always_comb begin
    prep.kind       = kind;
    prep.outer      = outer;
    prep.inner_prod = 14'(outer) * 14'(factor);
    prep.rate_neg   = turn_rate[7];
    prep.rate_pos   = !turn_rate[7] && (turn_rate != 8'sd0);
    prep.dir_neg    = turn_direction[9];
    prep.dir_pos    = !turn_direction[9] && (turn_direction != 10'sd0);
    prep.spin       = (spin_speed > FULL7) ? FULL7 : spin_speed;
  end

endmodule : dds_prep

`default_nettype wire

>>> hdl/dds_update.sv
// ----------------------------------------------------------------------------
// dds_update
// Computes the next wheel levels and the applied flag for one command.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_update
  import dds_pkg::*;
(
  input  prep_t             prep,
  input  logic signed [7:0] left_level,
  input  logic signed [7:0] right_level,
  output logic signed [7:0] left_next,
  output logic signed [7:0] right_next,
  output logic              applied_next
);

  localparam logic signed [7:0] FULL8  = 8'(FULL_SCALE);
  localparam logic signed [7:0] STEP8  = 8'(SPEED_STEP);
  localparam logic signed [7:0] FLOOR8 = 8'(SLOW_FLOOR);

  logic [26:0]       quot_prod;
  logic [6:0]        inner;
  logic signed [7:0] drv_l;
  logic signed [7:0] drv_r;
  logic signed [7:0] spin_s;
  logic signed [7:0] up_val;
  logic              levels_eq;

  // divide the inner product by 100 through the reciprocal
  always_comb begin
    quot_prod = 27'(prep.inner_prod) * 27'(RECIP_MUL);
    inner     = quot_prod[RECIP_SHIFT +: 7];
    drv_l     = {1'b0, (prep.rate_neg ? inner : prep.outer)};
    drv_r     = {1'b0, (prep.rate_pos ? inner : prep.outer)};
    spin_s    = {1'b0, prep.spin};
    levels_eq = (left_level == right_level);
    up_val    = (left_level + STEP8 > FULL8) ? FULL8 : left_level + STEP8;
  end

  // command decode
  always_comb begin
    left_next    = left_level;
    right_next   = right_level;
    applied_next = 1'b0;
    unique case (prep.kind)
      KIND_FORWARD: begin
        left_next    = drv_l;
        right_next   = drv_r;
        applied_next = 1'b1;
      end
      KIND_BACKWARD: begin
        left_next    = -drv_l;
        right_next   = -drv_r;
        applied_next = 1'b1;
      end
      KIND_TURN: begin
        if (prep.dir_neg) begin
          left_next    = -spin_s;
          right_next   = spin_s;
          applied_next = 1'b1;
        end else if (prep.dir_pos) begin
          left_next    = spin_s;
          right_next   = -spin_s;
          applied_next = 1'b1;
        end
      end
      KIND_STOP: begin
        left_next    = 8'sd0;
        right_next   = 8'sd0;
        applied_next = 1'b1;
      end
      KIND_SPEED_UP: begin
        if (levels_eq && left_level > 8'sd0 && left_level < FULL8) begin
          left_next    = up_val;
          right_next   = up_val;
          applied_next = 1'b1;
        end
      end
      KIND_SLOW_DOWN: begin
        if (levels_eq && left_level >= FLOOR8) begin
          left_next    = left_level - STEP8;
          right_next   = right_level - STEP8;
          applied_next = 1'b1;
        end
      end
      default: begin
        applied_next = 1'b0;
      end
    endcase
  end

endmodule : dds_update

`default_nettype wire
